@@ rtl/core/ac_pkg.sv @@
// Package for the Aho-Corasick matcher: item structs, kind codes, sequencer states.
// No dependencies.
package ac_pkg;

	localparam int NODES_DEF    = 256;
	localparam int SYMBOLS_DEF  = 27;
	localparam int PATTERNS_DEF = 32;
	localparam int POS_BITS     = 20;
	localparam int MAX_OUT      = 32;

	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_Z = 8'h7a;

	localparam logic [2:0] KIND_CLEAR    = 3'd0;
	localparam logic [2:0] KIND_PAT_BYTE = 3'd1;
	localparam logic [2:0] KIND_PAT_END  = 3'd2;
	localparam logic [2:0] KIND_BUILD    = 3'd3;
	localparam logic [2:0] KIND_TEXT     = 3'd4;
	localparam logic [2:0] KIND_RESTART  = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] symbol;
		logic [4:0] pattern_id;
	} cmd_t;

	typedef struct packed {
		logic                matched;
		logic [4:0]          match_id;
		logic [POS_BITS-1:0] position;
		logic                last;
		logic                overflow;
	} res_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_PB_CHK,
		ST_ZERO,
		ST_PE_WR,
		ST_BR_RD,
		ST_BR_CHK,
		ST_BQ_RD,
		ST_BQ_WAIT,
		ST_BF_WAIT,
		ST_BV_RD,
		ST_BT_RD,
		ST_BC_CHK,
		ST_DONE,
		ST_TX_NODE,
		ST_TX_RD,
		ST_TX_LOAD,
		ST_TX_SCAN,
		ST_TX_END
	} state_t;

endpackage

@@ rtl/core/ac_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/aho_corasick_matcher.sv @@
// Aho-Corasick multi-pattern matcher top level: sequencer over goto, failure,
// match mask and queue memories. Depends on ac_pkg and ac_ram.
//
// Usage: items enter on cmd (cmd_valid/cmd_stall), results leave on res
// (res_valid/res_stall). cmd_stall is low only while the sequencer is idle.
// Pattern byte: a goto read and check, plus zeroing the row of a new node.
// Pattern end: a mask write. Build: a breadth-first pass over the trie, paced
// by the single goto memory read port (two goto reads per symbol), then
// one build-done result. Text byte: a goto step, then for each failure-chain
// node a mask and failure read and a scan of its mask, one result per match;
// results leave through a one-entry output register, the last of an item
// carries last. Clear all and restart: clear zeroes the root row, restart
// resets the current node and position. After reset the block clears the
// root row with cmd_stall high. When res_stall holds, the result stays put
// and the sequencer waits before it presents another.
module aho_corasick_matcher #(
	parameter int NODES    = ac_pkg::NODES_DEF,
	parameter int SYMBOLS  = ac_pkg::SYMBOLS_DEF,
	parameter int PATTERNS = ac_pkg::PATTERNS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_stall,
	input  ac_pkg::cmd_t cmd,
	output logic         res_valid,
	input  logic         res_stall,
	output ac_pkg::res_t res
);

	localparam int NB = $clog2(NODES);
	localparam int AB = $clog2(NODES * SYMBOLS);
	localparam int CB = $clog2(SYMBOLS);
	localparam int PB = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
	localparam int NW = $clog2(ac_pkg::MAX_OUT) + 1;

	ac_pkg::state_t state_q, state_d;

	logic [NB:0]      count_q, tail_q, head_q, steps_q;
	logic [NB-1:0]    cursor_q, cur_q, t_q, nf_q, p_q, f_q, v_q;
	logic [AB-1:0]    idx_q;
	logic [CB-1:0]    cidx_q;
	logic [4:0]       id_q;
	logic [ac_pkg::POS_BITS-1:0] pos_q;
	logic             ovf_q, built_q;
	logic [PATTERNS-1:0] mask_q;
	logic [NW-1:0]    n_q;
	logic             pend_valid_q;
	logic [4:0]       pend_id_q;
	ac_pkg::res_t     res_q;
	logic             res_valid_q;

	logic             g_we, f_we, m_we, q_we;
	logic [AB-1:0]    g_wa, g_ra;
	logic [NB-1:0]    g_wd, g_rd, f_wa, f_wd, f_ra, f_rd, q_wa, q_wd, q_ra, q_rd;
	logic [NB-1:0]    m_wa, m_ra;
	logic [PATTERNS-1:0] m_wd, m_rd;
	logic             push;
	ac_pkg::res_t     push_data;

	logic [CB-1:0]    cmd_code;
	logic             slot_free, scan_done, chain_stop, cidx_last;
	logic [PB-1:0]    lo_bit;

	function automatic logic [CB-1:0] sym_code(input logic [7:0] b);
		logic [8:0] c;
		c = 9'd0;
		if (b >= ac_pkg::CHAR_A && b <= ac_pkg::CHAR_Z) begin
			c = 9'(b) - 9'(ac_pkg::CHAR_A) + 9'd1;
		end
		if (c >= 9'(SYMBOLS)) begin
			c = 9'd0;
		end
		return CB'(c);
	endfunction

	function automatic logic [AB-1:0] gaddr(input logic [NB-1:0] node, input logic [CB-1:0] c);
		return AB'(AB'(node) * AB'(SYMBOLS) + AB'(c));
	endfunction

	ac_ram #(.WIDTH(NB), .DEPTH(NODES * SYMBOLS)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
	ac_ram #(.WIDTH(NB), .DEPTH(NODES)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
	ac_ram #(.WIDTH(PATTERNS), .DEPTH(NODES)) u_mask (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
	ac_ram #(.WIDTH(NB), .DEPTH(NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

	assign cmd_code   = sym_code(cmd.symbol);
	assign slot_free  = !res_valid_q || !res_stall;
	assign cidx_last  = (cidx_q == CB'(SYMBOLS - 1));
	assign scan_done  = (mask_q == '0) || (n_q >= NW'(ac_pkg::MAX_OUT));
	assign chain_stop = (t_q == '0) || (steps_q >= (NB+1)'(NODES))
		|| (n_q >= NW'(ac_pkg::MAX_OUT));
	assign cmd_stall  = (state_q != ac_pkg::ST_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		lo_bit = '0;
		for (int i = PATTERNS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				lo_bit = PB'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ac_pkg::ST_INIT: if (cidx_last) state_d = ac_pkg::ST_IDLE;
			ac_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						ac_pkg::KIND_CLEAR:    state_d = ac_pkg::ST_INIT;
						ac_pkg::KIND_PAT_BYTE: if (!built_q) state_d = ac_pkg::ST_PB_CHK;
						ac_pkg::KIND_PAT_END: begin
							if (!built_q && cursor_q != '0 && 32'(cmd.pattern_id) < PATTERNS)
								state_d = ac_pkg::ST_PE_WR;
						end
						ac_pkg::KIND_BUILD:
							state_d = built_q ? ac_pkg::ST_DONE : ac_pkg::ST_BR_RD;
						ac_pkg::KIND_TEXT:     state_d = ac_pkg::ST_TX_NODE;
						default:               state_d = ac_pkg::ST_IDLE;
					endcase
				end
			end
			ac_pkg::ST_PB_CHK: begin
				if (g_rd == '0 && count_q < (NB+1)'(NODES)) state_d = ac_pkg::ST_ZERO;
				else state_d = ac_pkg::ST_IDLE;
			end
			ac_pkg::ST_ZERO:    if (cidx_last) state_d = ac_pkg::ST_IDLE;
			ac_pkg::ST_PE_WR:   state_d = ac_pkg::ST_IDLE;
			ac_pkg::ST_BR_RD:   state_d = ac_pkg::ST_BR_CHK;
			ac_pkg::ST_BR_CHK:  state_d = cidx_last ? ac_pkg::ST_BQ_RD : ac_pkg::ST_BR_RD;
			ac_pkg::ST_BQ_RD:
				state_d = (head_q == tail_q) ? ac_pkg::ST_DONE : ac_pkg::ST_BQ_WAIT;
			ac_pkg::ST_BQ_WAIT: state_d = ac_pkg::ST_BF_WAIT;
			ac_pkg::ST_BF_WAIT: state_d = ac_pkg::ST_BV_RD;
			ac_pkg::ST_BV_RD:   state_d = ac_pkg::ST_BT_RD;
			ac_pkg::ST_BT_RD:   state_d = ac_pkg::ST_BC_CHK;
			ac_pkg::ST_BC_CHK:  state_d = cidx_last ? ac_pkg::ST_BQ_RD : ac_pkg::ST_BV_RD;
			ac_pkg::ST_DONE:    if (slot_free) state_d = ac_pkg::ST_IDLE;
			ac_pkg::ST_TX_NODE: state_d = ac_pkg::ST_TX_RD;
			ac_pkg::ST_TX_RD:   state_d = chain_stop ? ac_pkg::ST_TX_END : ac_pkg::ST_TX_LOAD;
			ac_pkg::ST_TX_LOAD: state_d = ac_pkg::ST_TX_SCAN;
			ac_pkg::ST_TX_SCAN: begin
				if (scan_done) state_d = built_q ? ac_pkg::ST_TX_RD : ac_pkg::ST_TX_END;
			end
			ac_pkg::ST_TX_END:  if (slot_free) state_d = ac_pkg::ST_IDLE;
			default:            state_d = ac_pkg::ST_IDLE;
		endcase
	end

	// memory ports and result push
	always_comb begin
		g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
		f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
		m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = '0;
		q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
		push = 1'b0;
		push_data = '0;
		push_data.overflow = ovf_q;
		case (state_q)
			ac_pkg::ST_INIT: begin
				g_we = 1'b1;
				g_wa = AB'(cidx_q);
			end
			ac_pkg::ST_IDLE: begin
				if (cmd.kind == ac_pkg::KIND_TEXT) g_ra = gaddr(cur_q, cmd_code);
				else g_ra = gaddr(cursor_q, cmd_code);
				m_ra = cursor_q;
			end
			ac_pkg::ST_PB_CHK: begin
				if (g_rd == '0 && count_q < (NB+1)'(NODES)) begin
					g_we = 1'b1;
					g_wa = idx_q;
					g_wd = count_q[NB-1:0];
					m_we = 1'b1;
					m_wa = count_q[NB-1:0];
				end
			end
			ac_pkg::ST_ZERO: begin
				g_we = 1'b1;
				g_wa = gaddr(cursor_q, cidx_q);
			end
			ac_pkg::ST_PE_WR: begin
				m_we = 1'b1;
				m_wa = cursor_q;
				m_wd = m_rd | (PATTERNS'(1) << id_q);
			end
			ac_pkg::ST_BR_RD: g_ra = AB'(cidx_q);
			ac_pkg::ST_BR_CHK: begin
				if (g_rd != '0) begin
					f_we = 1'b1;
					f_wa = g_rd;
					q_we = (tail_q < (NB+1)'(NODES));
					q_wa = tail_q[NB-1:0];
					q_wd = g_rd;
				end
			end
			ac_pkg::ST_BQ_RD:   q_ra = head_q[NB-1:0];
			ac_pkg::ST_BQ_WAIT: f_ra = q_rd;
			ac_pkg::ST_BV_RD:   g_ra = gaddr(p_q, cidx_q);
			ac_pkg::ST_BT_RD:   g_ra = gaddr(f_q, cidx_q);
			ac_pkg::ST_BC_CHK: begin
				if (v_q != '0) begin
					f_we = 1'b1;
					f_wa = v_q;
					f_wd = g_rd;
					q_we = (tail_q < (NB+1)'(NODES));
					q_wa = tail_q[NB-1:0];
					q_wd = v_q;
				end else begin
					g_we = 1'b1;
					g_wa = gaddr(p_q, cidx_q);
					g_wd = g_rd;
				end
			end
			ac_pkg::ST_DONE: begin
				push = slot_free;
				push_data.last = 1'b1;
			end
			ac_pkg::ST_TX_RD: begin
				m_ra = t_q;
				f_ra = t_q;
			end
			ac_pkg::ST_TX_SCAN: begin
				push = !scan_done && pend_valid_q && slot_free;
				push_data.matched  = 1'b1;
				push_data.match_id = pend_id_q;
				push_data.position = pos_q;
			end
			ac_pkg::ST_TX_END: begin
				push = slot_free;
				push_data.matched  = pend_valid_q;
				push_data.match_id = pend_valid_q ? pend_id_q : '0;
				push_data.position = pos_q;
				push_data.last     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ac_pkg::ST_INIT;
			count_q      <= (NB+1)'(1);
			cursor_q     <= '0;
			cur_q        <= '0;
			pos_q        <= '0;
			ovf_q        <= 1'b0;
			built_q      <= 1'b0;
			cidx_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			steps_q      <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			case (state_q)
				ac_pkg::ST_INIT, ac_pkg::ST_ZERO: cidx_q <= cidx_last ? '0 : cidx_q + CB'(1);
				ac_pkg::ST_IDLE: begin
					id_q   <= cmd.pattern_id;
					idx_q  <= gaddr(cursor_q, cmd_code);
					cidx_q <= '0;
					head_q <= '0;
					tail_q <= '0;
					if (cmd_valid) begin
						case (cmd.kind)
							ac_pkg::KIND_CLEAR: begin
								count_q  <= (NB+1)'(1);
								cursor_q <= '0;
								cur_q    <= '0;
								pos_q    <= '0;
								ovf_q    <= 1'b0;
								built_q  <= 1'b0;
							end
							ac_pkg::KIND_PAT_END: begin
								if (!built_q && !(cursor_q != '0
									&& 32'(cmd.pattern_id) < PATTERNS))
									cursor_q <= '0;
							end
							ac_pkg::KIND_TEXT: if (pos_q != '1) pos_q <= pos_q + 1'b1;
							ac_pkg::KIND_RESTART: begin
								cur_q <= '0;
								pos_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ac_pkg::ST_PB_CHK: begin
					if (g_rd != '0) begin
						cursor_q <= g_rd;
					end else if (count_q < (NB+1)'(NODES)) begin
						cursor_q <= count_q[NB-1:0];
						count_q  <= count_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				ac_pkg::ST_PE_WR: cursor_q <= '0;
				ac_pkg::ST_BR_CHK: begin
					if (g_rd != '0 && tail_q < (NB+1)'(NODES)) tail_q <= tail_q + 1'b1;
					cidx_q <= cidx_last ? '0 : cidx_q + CB'(1);
				end
				ac_pkg::ST_BQ_RD: begin
					if (head_q == tail_q) built_q <= 1'b1;
					else head_q <= head_q + 1'b1;
				end
				ac_pkg::ST_BQ_WAIT: p_q <= q_rd;
				ac_pkg::ST_BF_WAIT: begin
					f_q    <= f_rd;
					cidx_q <= '0;
				end
				ac_pkg::ST_BT_RD: v_q <= g_rd;
				ac_pkg::ST_BC_CHK: begin
					if (v_q != '0 && tail_q < (NB+1)'(NODES)) tail_q <= tail_q + 1'b1;
					cidx_q <= cidx_last ? '0 : cidx_q + CB'(1);
				end
				ac_pkg::ST_TX_NODE: begin
					cur_q        <= g_rd;
					t_q          <= g_rd;
					steps_q      <= '0;
					n_q          <= '0;
					pend_valid_q <= 1'b0;
				end
				ac_pkg::ST_TX_LOAD: begin
					mask_q  <= m_rd;
					nf_q    <= f_rd;
					steps_q <= steps_q + 1'b1;
				end
				ac_pkg::ST_TX_SCAN: begin
					if (scan_done) begin
						t_q <= nf_q;
					end else if (!pend_valid_q || slot_free) begin
						pend_valid_q <= 1'b1;
						pend_id_q    <= 5'(lo_bit);
						n_q          <= n_q + 1'b1;
						mask_q       <= mask_q & ~(PATTERNS'(1) << lo_bit);
					end
				end
				ac_pkg::ST_TX_END: if (slot_free) pend_valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) res_q <= push_data;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= (NB+1)'(1) && count_q <= (NB+1)'(NODES))
		else $error("node count out of range");
	a_cursor_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(NB+1)'(cursor_q) < count_q)
		else $error("insert cursor beyond allocated nodes");
	a_current_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(NB+1)'(cur_q) < count_q)
		else $error("current node beyond allocated nodes");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");
	a_out_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(ac_pkg::MAX_OUT))
		else $error("result count above cap");

endmodule

@@ tb/aho_corasick_matcher_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for aho_corasick_matcher: builds pattern tries, scans text
// and checks every result item against an in-bench Aho-Corasick predictor. Depends on ac_pkg and aho_corasick_matcher.
module aho_corasick_matcher_test;

	localparam int N = ac_pkg::NODES_DEF;
	localparam int S = ac_pkg::SYMBOLS_DEF;
	localparam int P = ac_pkg::PATTERNS_DEF;
	localparam logic [ac_pkg::POS_BITS-1:0] POS_MAX = '1;

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_stall;
	ac_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1;
	ac_pkg::res_t res;

	aho_corasick_matcher dut (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #5 clk = ~clk;

	// trie mirror
	int unsigned trans[N*S];
	int unsigned fail_of[N];
	logic [P-1:0] ids_at[N];
	int unsigned n_nodes, cursor, cur_node;
	logic [ac_pkg::POS_BITS-1:0] text_pos;
	logic ovf, linked;

	ac_pkg::res_t expected_q[$];
	int errors = 0, n_items = 0, n_results = 0, n_hits = 0;
	int hold_cycles = 0;

	function automatic int unsigned code_of(logic [7:0] b);
		if (b >= ac_pkg::CHAR_A && b <= ac_pkg::CHAR_Z) return b - ac_pkg::CHAR_A + 1;
		return 0;
	endfunction

	function automatic void reset_trie();
		foreach (trans[i]) trans[i] = 0;
		foreach (fail_of[i]) fail_of[i] = 0;
		foreach (ids_at[i]) ids_at[i] = '0;
		n_nodes = 1; cursor = 0; cur_node = 0; text_pos = 0; ovf = 0; linked = 0;
	endfunction

	function automatic void link_failures();
		int unsigned fifo[$];
		int unsigned p, f, v, t;
		for (int c = 0; c < S; c++)
			if (trans[c] != 0) begin
				fail_of[trans[c]] = 0;
				fifo.push_back(trans[c]);
			end
		while (fifo.size() > 0) begin
			p = fifo.pop_front();
			f = fail_of[p];
			for (int c = 0; c < S; c++) begin
				v = trans[p*S+c];
				t = trans[f*S+c];
				if (v != 0) begin
					fail_of[v] = t;
					fifo.push_back(v);
				end else trans[p*S+c] = t;
			end
		end
		linked = 1;
	endfunction

	function automatic void predict_matches(ac_pkg::cmd_t c);
		ac_pkg::res_t r;
		int unsigned idx, t, steps, n;
		n = 0;
		case (c.kind)
			ac_pkg::KIND_CLEAR: reset_trie();
			ac_pkg::KIND_PAT_BYTE: if (!linked) begin
				idx = cursor*S + code_of(c.symbol);
				if (trans[idx] == 0) begin
					if (n_nodes < N) begin
						for (int k = 0; k < S; k++) trans[n_nodes*S+k] = 0;
						ids_at[n_nodes] = '0;
						trans[idx] = n_nodes;
						n_nodes++;
						cursor = trans[idx];
					end else ovf = 1;
				end else cursor = trans[idx];
			end
			ac_pkg::KIND_PAT_END: if (!linked) begin
				if (cursor != 0) ids_at[cursor][c.pattern_id] = 1'b1;
				cursor = 0;
			end
			ac_pkg::KIND_BUILD: begin
				if (!linked) link_failures();
				r = '0; r.last = 1; r.overflow = ovf;
				expected_q.push_back(r);
			end
			ac_pkg::KIND_TEXT: begin
				if (text_pos != POS_MAX) text_pos++;
				cur_node = trans[cur_node*S + code_of(c.symbol)];
				t = cur_node; steps = 0;
				while (t != 0 && steps < N && n < ac_pkg::MAX_OUT) begin
					for (int j = 0; j < P && n < ac_pkg::MAX_OUT; j++)
						if (ids_at[t][j]) begin
							r = '0; r.matched = 1; r.match_id = 5'(j);
							r.position = text_pos; r.overflow = ovf;
							expected_q.push_back(r);
							n++;
						end
					if (!linked) break;
					t = fail_of[t];
					steps++;
				end
				if (n == 0) begin
					r = '0; r.position = text_pos; r.last = 1; r.overflow = ovf;
					expected_q.push_back(r);
				end else expected_q[$].last = 1;
			end
			ac_pkg::KIND_RESTART: begin
				cur_node = 0; text_pos = 0;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, ac_pkg::res_t got, ac_pkg::res_t want);
		errors++;
		$display({"mismatch %s: got m=%0d id=%0d pos=%0d last=%0d ovf=%0d,",
			" want m=%0d id=%0d pos=%0d last=%0d ovf=%0d"},
			what, got.matched, got.match_id, got.position, got.last, got.overflow,
			want.matched, want.match_id, want.position, want.last, want.overflow);
	endtask

	// result side
	always @(posedge clk) begin
		ac_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (res.matched) n_hits++;
			if (expected_q.size() == 0) report_mismatch("unexpected", res, '0);
			else begin
				want = expected_q.pop_front();
				if (res !== want) report_mismatch("field", res, want);
			end
		end
	end

	// receiver stall: a random stall before each item, or a long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_stall <= 1;
			end else begin
				w = $urandom_range(0, 3);
				res_stall <= (w != 0);
				if (w != 0) begin
					repeat (w) @(negedge clk);
					res_stall <= 0;
				end
				@(posedge clk);
				while (!(res_valid && !res_stall)) @(posedge clk);
			end
		end
	end

	// valid stays high after acceptance until the next falling edge
	task automatic drive(ac_pkg::cmd_t c, int gap);
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	task automatic send(ac_pkg::cmd_t c, int gap);
		drive(c, gap);
		predict_matches(c);
		n_items++;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_valid <= 0;
		while (expected_q.size() > 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	function automatic ac_pkg::cmd_t mk(logic [2:0] k, logic [7:0] s, logic [4:0] id);
		ac_pkg::cmd_t c;
		c.kind = k; c.symbol = s; c.pattern_id = id;
		return c;
	endfunction

	function automatic logic [7:0] rand_letter(int span);
		if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
		return ac_pkg::CHAR_A + 8'($urandom_range(0, span - 1));
	endfunction

	typedef struct {
		ac_pkg::cmd_t c;
		logic check;
		ac_pkg::res_t want;
	} row_t;

	initial begin
		row_t rows[$];
		ac_pkg::res_t got_want;
		int plen, npat, span;
		reset_trie();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed: text before build, patterns with extremes, build, repeat build, scan
		rows.push_back('{mk(ac_pkg::KIND_TEXT, 8'h00, 5'd0), 1, '{0, 0, 20'd1, 1, 0}});
		rows.push_back('{mk(ac_pkg::KIND_PAT_BYTE, "a", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_PAT_END, 0, 5'd31), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_PAT_END, 0, 5'd3), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_PAT_BYTE, "z", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_PAT_BYTE, 8'hff, 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_PAT_END, 0, 5'd0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_PAT_BYTE, "b", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_PAT_BYTE, "a", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_PAT_END, 0, 5'd7), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_TEXT, "a", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_RESTART, 0, 0), 0, '0});
		rows.push_back('{mk(3'd6, 0, 0), 0, '0});
		rows.push_back('{mk(3'd7, 8'hff, 5'd31), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_BUILD, 0, 0), 1, '{0, 0, 20'd0, 1, 0}});
		rows.push_back('{mk(ac_pkg::KIND_PAT_BYTE, "q", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_BUILD, 0, 0), 1, '{0, 0, 20'd0, 1, 0}});
		rows.push_back('{mk(ac_pkg::KIND_TEXT, "b", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_TEXT, "a", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_TEXT, "z", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_TEXT, 8'hff, 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_TEXT, "a", 0), 0, '0});
		rows.push_back('{mk(ac_pkg::KIND_CLEAR, 0, 0), 0, '0});
		foreach (rows[i]) begin
			if (rows[i].check) begin
				predict_matches(rows[i].c);
				got_want = expected_q.pop_back();
				expected_q.push_back(rows[i].want);
				if (got_want !== rows[i].want) report_mismatch("table", got_want, rows[i].want);
				n_items++;
				drive(rows[i].c, $urandom_range(0, 3));
			end else send(rows[i].c, $urandom_range(0, 3));
		end
		drain();
		// random phases: build a dictionary, then scan text; phase 2 overflows the trie
		for (int ph = 0; n_items < 440; ph++) begin
			span = (ph % 3 == 0) ? 3 : 26;
			if (ph != 0) send(mk(ac_pkg::KIND_CLEAR, 0, 0), $urandom_range(0, 3));
			npat = (ph == 2) ? 18 : $urandom_range(1, 6);
			for (int p = 0; p < npat; p++) begin
				plen = (ph == 2) ? 16 : $urandom_range(0, 4);
				for (int k = 0; k < plen; k++)
					send(mk(ac_pkg::KIND_PAT_BYTE, rand_letter(span), 0), $urandom_range(0, 3));
				send(mk(ac_pkg::KIND_PAT_END, 0, 5'($urandom)), $urandom_range(0, 3));
			end
			if (ph == 2 || $urandom_range(0, 7) != 0)
				send(mk(ac_pkg::KIND_BUILD, 0, 0), $urandom_range(0, 3));
			if (ph == 1) hold_cycles = 300;
			for (int k = 0; k < 40; k++) begin
				if ($urandom_range(0, 30) == 0) send(mk(ac_pkg::KIND_RESTART, 0, 0), 0);
				else if ($urandom_range(0, 40) == 0)
					send(mk(3'($urandom_range(0, 7)), 8'($urandom), 5'($urandom)), 0);
				else send(mk(ac_pkg::KIND_TEXT, rand_letter(span), 5'($urandom)),
					$urandom_range(0, 3));
			end
			if (ph == 2) drain();
		end
		drain();
		$display("run covered corner rows, small and full dictionaries with node overflow,");
		$display("a long receiver hold-off and random scans: %0d items, %0d results, %0d matches",
			n_items, n_results, n_hits);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
